FILE: design/nplap_pkg.sv
// Shared constants and types for the nine-point Laplacian stencil.
`default_nettype none
package nplap_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned ResultW    = 20;
  localparam int unsigned RowW       = 16;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned GridWidthW = 11;
  localparam int unsigned GridHgtW   = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned MinDim     = 3;

  localparam logic [GridWidthW-1:0] GridWidthReset = GridWidthW'(1024);
  localparam logic [GridHgtW-1:0]   GridHgtReset   = GridHgtW'(1024);

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridWidth  = 1'b0,
    CfgGridHeight = 1'b1
  } cfg_idx_e;

  // One stored column entry: upper row sample and middle row sample.
  typedef struct packed {
    logic signed [SampleW-1:0] upper;
    logic signed [SampleW-1:0] middle;
  } line_entry_t;

endpackage
`default_nettype wire

FILE: design/nplap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module nplap_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: design/nine_point_laplace_stencil_top.sv
// Nine-point Laplacian stencil over a raster-scanned grid: top level.
//
// Samples enter row by row, one beat per clock when the result side does not
// stall. On accept a beat registers the sample in stage 1 and reads the
// line-buffer RAM at the current column; when it leaves stage 1 it adds the
// 3x3 window into the result register and writes the column back. A result
// is emitted for every interior point (r, c) when the sample at (r+1, c+1)
// has been accepted; border points give no result beat. Sustained rate is
// one sample per cycle while the result side does not stall; the adder tree
// is combinational and the line-buffer RAM takes one read plus one write per
// cycle. grid_width is clamped to 3..1024 and grid_height to at least 3; write
// the registers only while the block is idle. The line buffer has no reset.
`default_nettype none
module nine_point_laplace_stencil_top (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // sample channel
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic signed [nplap_pkg::SampleW-1:0]   sample_i,
  // result channel
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed      [nplap_pkg::ResultW-1:0]   result_value_o,
  output logic             [nplap_pkg::RowW-1:0]      center_row_o,
  output logic             [nplap_pkg::ColW-1:0]      center_col_o,
  output logic                                        last_result_o,
  // configuration
  input  wire logic                                   cfg_we_i,
  input  wire logic        [nplap_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic        [nplap_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned SW = nplap_pkg::SampleW;
  localparam int unsigned RW = nplap_pkg::ResultW;

  // configuration registers
  logic [nplap_pkg::GridWidthW-1:0] grid_width_q;
  logic [nplap_pkg::GridHgtW-1:0]   grid_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= nplap_pkg::GridWidthReset;
      grid_height_q <= nplap_pkg::GridHgtReset;
    end else if (cfg_we_i) begin
      case (nplap_pkg::cfg_idx_e'(cfg_idx_i))
        nplap_pkg::CfgGridWidth:  grid_width_q  <= cfg_data_i[nplap_pkg::GridWidthW-1:0];
        nplap_pkg::CfgGridHeight: grid_height_q <= cfg_data_i[nplap_pkg::GridHgtW-1:0];
        default: ;
      endcase
    end
  end

  // clamped bounds
  logic [nplap_pkg::GridWidthW-1:0] eff_width;
  logic [nplap_pkg::GridHgtW-1:0]   eff_height;

  always_comb begin
    eff_width = grid_width_q;
    if (grid_width_q < nplap_pkg::GridWidthW'(nplap_pkg::MinDim)) begin
      eff_width = nplap_pkg::GridWidthW'(nplap_pkg::MinDim);
    end else if (grid_width_q > nplap_pkg::GridWidthW'(nplap_pkg::MaxWidth)) begin
      eff_width = nplap_pkg::GridWidthW'(nplap_pkg::MaxWidth);
    end
    eff_height = grid_height_q;
    if (grid_height_q < nplap_pkg::GridHgtW'(nplap_pkg::MinDim)) begin
      eff_height = nplap_pkg::GridHgtW'(nplap_pkg::MinDim);
    end
  end

  // raster counters
  logic [nplap_pkg::ColW-1:0] col_count_q, col_count_d;
  logic [nplap_pkg::RowW-1:0] row_count_q, row_count_d;
  logic                       col_end, row_end, emit;

  assign col_end = ({1'b0, col_count_q} + nplap_pkg::GridWidthW'(1)) >= eff_width;
  assign row_end = ({1'b0, row_count_q} + (nplap_pkg::RowW + 1)'(1)) >= {1'b0, eff_height};
  assign emit    = (row_count_q >= nplap_pkg::RowW'(2)) && (col_count_q >= nplap_pkg::ColW'(2));

  always_comb begin
    col_count_d = col_count_q + nplap_pkg::ColW'(1);
    row_count_d = row_count_q;
    if (col_end) begin
      col_count_d = '0;
      row_count_d = row_end ? '0 : row_count_q + nplap_pkg::RowW'(1);
    end
  end

  // input stage
  logic                       in_accept, s1_adv;
  logic                       s1_valid_q;
  logic signed [SW-1:0]       s1_sample_q;
  logic [nplap_pkg::ColW-1:0] s1_col_q;
  logic [nplap_pkg::RowW-1:0] s1_row_q;
  logic                       s1_emit_q, s1_last_q;

  assign s1_adv     = s1_valid_q && (!s1_emit_q || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      col_count_q <= '0;
      row_count_q <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q  <= 1'b1;
        col_count_q <= col_count_d;
        row_count_q <= row_count_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_i;
      s1_col_q    <= col_count_q;
      s1_row_q    <= row_count_q;
      s1_emit_q   <= emit;
      s1_last_q   <= col_end && row_end;
    end
  end

  // line buffer: read on accept, write back the column when the beat leaves stage 1
  nplap_pkg::line_entry_t rd_entry, wr_entry;

  assign wr_entry.upper  = rd_entry.middle;
  assign wr_entry.middle = s1_sample_q;

  nplap_ram #(
    .Width($bits(nplap_pkg::line_entry_t)),
    .Depth(nplap_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_col_q),
    .wdata_i(wr_entry),
    .re_i   (in_accept),
    .raddr_i(col_count_q),
    .rdata_o(rd_entry)
  );

  // 3x3 window: columns c-2 and c-1 of the three rows
  logic signed [SW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[1];
      win_q[1] <= rd_entry.upper;
      win_q[2] <= win_q[3];
      win_q[3] <= rd_entry.middle;
      win_q[4] <= win_q[5];
      win_q[5] <= s1_sample_q;
    end
  end

  // stencil
  logic signed [RW-1:0] neigh_sum, result_d;

  always_comb begin
    neigh_sum = RW'(win_q[0]) + RW'(win_q[1]) + RW'(rd_entry.upper)
              + RW'(win_q[2]) + RW'(rd_entry.middle)
              + RW'(win_q[4]) + RW'(win_q[5]) + RW'(s1_sample_q);
    result_d  = (RW'(win_q[3]) <<< 3) - neigh_sum;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      result_value_o <= result_d;
      center_row_o   <= s1_row_q - nplap_pkg::RowW'(1);
      center_col_o   <= s1_col_q - nplap_pkg::ColW'(1);
      last_result_o  <= s1_last_q;
    end
  end

  // checks
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted beat not held in stage 1");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> (out_valid_o && !out_ready_i))
    else $error("stage 1 held without a result stall");

  a_emit_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_emit_q) |=> out_valid_o)
    else $error("interior beat produced no result");

  a_interior_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (center_col_o != '0 && center_row_o != '0))
    else $error("result for a border point");

endmodule
`default_nettype wire
